/* src/rhc_pkg.sv */
// Shared types and codes for the RGB/HSV converter.
// No dependencies; imported by every module of the block.
package rhc_pkg;

    // Lanes in the divider chain: hue/sat/- forward, p/q/t inverse
    localparam int NUM_LANES = 3;

    typedef enum logic {
        DIR_FWD = 1'b0,  // RGB to HSV
        DIR_INV = 1'b1   // HSV to RGB
    } dir_t;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sect_t;

endpackage

/* src/rhc_prep.sv */
// Front end of the converter: three registered stages that turn a pixel into
// numerator/divisor pairs for the divider chain. Depends on rhc_pkg.
module rhc_prep
    import rhc_pkg::*;
#(
    parameter int B = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  dir_t                in_dir,
    input  logic [B-1:0]        c0,
    input  logic [B-1:0]        c1,
    input  logic [B-1:0]        c2,
    output logic                out_valid,
    output logic [2*B+2:0]      num [NUM_LANES],
    output logic [B+2:0]        den [NUM_LANES],
    output logic [B+5:0]        side
);
    localparam int NW = 2 * B + 3;
    localparam int DW = B + 3;
    localparam logic [B-1:0]   M       = {B{1'b1}};
    localparam logic [B:0]     HUE_ONE = {1'b1, {B{1'b0}}};
    localparam logic [2*B-1:0] FULL    = {M, {B{1'b0}}};

    // stage a: min/max and hue numerator, or hue sector and fraction
    logic [B-1:0] hi, lo, span;
    logic         r_max, g_max;
    logic [B+2:0] span6, fnum;
    logic [B+2:0] h6;

    always_comb begin
        hi = c0;
        lo = c0;
        if (c1 > hi) hi = c1;
        if (c2 > hi) hi = c2;
        if (c1 < lo) lo = c1;
        if (c2 < lo) lo = c2;
        span  = hi - lo;
        r_max = (hi == c0);
        g_max = !r_max && (hi == c1);
        span6 = ((B+3)'(span) << 2) + ((B+3)'(span) << 1);
        if (r_max) begin
            fnum = (c1 >= c2) ? (B+3)'(c1 - c2) : span6 - (B+3)'(c2 - c1);
        end else if (g_max) begin
            fnum = ((B+3)'(span) << 1) + (B+3)'(c2) - (B+3)'(c0);
        end else begin
            fnum = ((B+3)'(span) << 2) + (B+3)'(c0) - (B+3)'(c1);
        end
        h6 = ((B+3)'(c0) << 2) + ((B+3)'(c0) << 1);
    end

    logic         a_v_reg;
    dir_t         a_dir_reg;
    logic [B-1:0] a_hi_reg, a_span_reg, a_f_reg, a_s_reg, a_val_reg;
    logic [B+2:0] a_fnum_reg;
    logic [2:0]   a_sect_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= in_valid;
        end
        if (en) begin
            a_dir_reg  <= in_dir;
            a_hi_reg   <= hi;
            a_span_reg <= span;
            a_fnum_reg <= fnum;
            a_sect_reg <= h6[B+2:B];
            a_f_reg    <= h6[B-1:0];
            a_s_reg    <= c1;
            a_val_reg  <= c2;
        end
    end

    // stage b: forward operands finished; inverse s*f products
    logic         b_v_reg;
    dir_t         b_dir_reg;
    logic [2:0]   b_sect_reg;
    logic [B-1:0] b_val_reg, b_ms_reg;
    logic         b_zspan_reg, b_zmax_reg;
    logic [NW-1:0] b_n0_reg, b_n1_reg;
    logic [DW-1:0] b_d0_reg, b_d1_reg;
    logic [2*B-1:0] b_sf_reg;
    logic [2*B:0]   b_st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (en) begin
            b_v_reg <= a_v_reg;
        end
        if (en) begin
            b_dir_reg   <= a_dir_reg;
            b_sect_reg  <= a_sect_reg;
            b_val_reg   <= (a_dir_reg == DIR_FWD) ? a_hi_reg : a_val_reg;
            b_zspan_reg <= (a_span_reg == '0);
            b_zmax_reg  <= (a_hi_reg == '0);
            b_n0_reg    <= NW'(a_fnum_reg) << B;
            b_d0_reg    <= (DW'(a_span_reg) << 2) + (DW'(a_span_reg) << 1);
            b_n1_reg    <= (NW'(a_span_reg) << B) - NW'(a_span_reg);
            b_d1_reg    <= DW'(a_hi_reg);
            b_ms_reg    <= M - a_s_reg;
            b_sf_reg    <= (2*B)'(a_s_reg) * (2*B)'(a_f_reg);
            b_st_reg    <= (2*B+1)'(a_s_reg) * (2*B+1)'(HUE_ONE - (B+1)'(a_f_reg));
        end
    end

    // stage c: v times the inverse terms, then the divide by M = 2^B-1 done as
    // (x + (x >> B) + 1) >> B, exact for x up to M*M; the inverse lanes then
    // carry p/q/t through the divider cells with a unit divisor
    logic [2*B-1:0] np;
    logic [3*B-1:0] nq, nt;
    logic [2*B-1:0] q_fac, t_fac;
    logic [2*B-1:0] p_sum, q_sum, t_sum;

    always_comb begin
        q_fac = FULL - b_sf_reg;
        t_fac = (2*B)'((2*B+1)'(FULL) - b_st_reg);
        np = (2*B)'(b_val_reg) * (2*B)'(b_ms_reg);
        nq = ((3*B)'(b_val_reg) * (3*B)'(q_fac)) >> B;
        nt = ((3*B)'(b_val_reg) * (3*B)'(t_fac)) >> B;
        p_sum = np + (np >> B) + (2*B)'(1);
        q_sum = nq[2*B-1:0] + (nq[2*B-1:0] >> B) + (2*B)'(1);
        t_sum = nt[2*B-1:0] + (nt[2*B-1:0] >> B) + (2*B)'(1);
    end

    logic c_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
        end else if (en) begin
            c_v_reg <= b_v_reg;
        end
        if (en) begin
            side <= {b_dir_reg, b_sect_reg, b_zspan_reg, b_zmax_reg, b_val_reg};
            if (b_dir_reg == DIR_FWD) begin
                num[0] <= b_n0_reg;
                den[0] <= b_d0_reg;
                num[1] <= b_n1_reg;
                den[1] <= b_d1_reg;
                num[2] <= '0;
                den[2] <= DW'(1);
            end else begin
                num[0] <= NW'(p_sum[2*B-1:B]);
                num[1] <= NW'(q_sum[2*B-1:B]);
                num[2] <= NW'(t_sum[2*B-1:B]);
                den[0] <= DW'(1);
                den[1] <= DW'(1);
                den[2] <= DW'(1);
            end
        end
    end

    assign out_valid = c_v_reg;

endmodule

/* src/rhc_div_cell.sv */
// One cell of the restoring divider chain: settles quotient bit SHIFT in
// every lane and hands remainder, divisor and sideband on. Depends on rhc_pkg.
module rhc_div_cell
    import rhc_pkg::*;
#(
    parameter int B     = 12,
    parameter int SHIFT = 0,
    parameter int SW    = 18
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           valid_in,
    input  logic [2*B+2:0] rem_in  [NUM_LANES],
    input  logic [B+2:0]   den_in  [NUM_LANES],
    input  logic [B-1:0]   quot_in [NUM_LANES],
    input  logic [SW-1:0]  side_in,
    output logic           valid_out,
    output logic [2*B+2:0] rem_out  [NUM_LANES],
    output logic [B+2:0]   den_out  [NUM_LANES],
    output logic [B-1:0]   quot_out [NUM_LANES],
    output logic [SW-1:0]  side_out
);
    localparam int NW = 2 * B + 3;

    logic [NW-1:0] dsh     [NUM_LANES];
    logic [NW-1:0] rem_nxt [NUM_LANES];
    logic [B-1:0]  q_nxt   [NUM_LANES];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            dsh[l] = NW'(den_in[l]) << SHIFT;
            if (rem_in[l] >= dsh[l]) begin
                rem_nxt[l] = rem_in[l] - dsh[l];
                q_nxt[l]   = quot_in[l] | (B'(1) << SHIFT);
            end else begin
                rem_nxt[l] = rem_in[l];
                q_nxt[l]   = quot_in[l];
            end
        end
    end

    logic valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
        if (en) begin
            rem_out  <= rem_nxt;
            den_out  <= den_in;
            quot_out <= q_nxt;
            side_out <= side_in;
        end
    end

    assign valid_out = valid_reg;

endmodule

/* src/rgb_hsv_converter_top.sv */
// Throughput: one pixel per cycle while the skid register is empty; three front-end stages,
// one divider cell per quotient bit, then an output register backed by a one-entry skid register.
// Reset (aresetn low, synchronous) empties the pipeline and sets direction to RGB->HSV.
// Depends on rhc_pkg, rhc_prep and rhc_div_cell.
module rgb_hsv_converter_top
    import rhc_pkg::*;
#(
    parameter int COMPONENT_BITS = 12
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_wen,
    input  logic cfg_wdata,                 // direction: 0 RGB->HSV, 1 HSV->RGB
    input  logic s_tvalid,
    output logic s_tready,
    // chan0_in, chan1_in, chan2_in from bit 0 up, zero padded
    input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // chan0_out, chan1_out, chan2_out from bit 0 up, zero padded
    output logic [((3*COMPONENT_BITS+7)/8)*8-1:0] m_tdata
);
    localparam int B  = COMPONENT_BITS;
    localparam int DW_BUS = ((3*B+7)/8)*8;
    localparam int NW = 2 * B + 3;
    localparam int SW = B + 6;

    dir_t dir_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= DIR_FWD;
        end else if (cfg_wen) begin
            dir_reg <= dir_t'(cfg_wdata);
        end
    end

    logic en;
    logic skid_v_reg;
    assign en       = !skid_v_reg;
    assign s_tready = en;

    logic          c_valid [B+1];
    logic [NW-1:0] c_rem   [B+1][NUM_LANES];
    logic [B+2:0]  c_den   [B+1][NUM_LANES];
    logic [B-1:0]  c_quot  [B+1][NUM_LANES];
    logic [SW-1:0] c_side  [B+1];

    rhc_prep #(.B(B)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_dir    (dir_reg),
        .c0        (s_tdata[B-1:0]),
        .c1        (s_tdata[2*B-1:B]),
        .c2        (s_tdata[3*B-1:2*B]),
        .out_valid (c_valid[0]),
        .num       (c_rem[0]),
        .den       (c_den[0]),
        .side      (c_side[0])
    );

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            c_quot[0][l] = '0;
        end
    end

    for (genvar i = 0; i < B; i++) begin : g_cell
        rhc_div_cell #(.B(B), .SHIFT(B-1-i), .SW(SW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (c_valid[i]),
            .rem_in    (c_rem[i]),
            .den_in    (c_den[i]),
            .quot_in   (c_quot[i]),
            .side_in   (c_side[i]),
            .valid_out (c_valid[i+1]),
            .rem_out   (c_rem[i+1]),
            .den_out   (c_den[i+1]),
            .quot_out  (c_quot[i+1]),
            .side_out  (c_side[i+1])
        );
    end

    // result assembly
    dir_t         r_dir;
    logic [2:0]   r_sect;
    logic         r_zspan, r_zmax;
    logic [B-1:0] r_val, q0, q1, q2;
    logic [B-1:0] o0, o1, o2;
    logic [DW_BUS-1:0] res;

    always_comb begin
        r_dir   = dir_t'(c_side[B][B+5]);
        r_sect  = c_side[B][B+4:B+2];
        r_zspan = c_side[B][B+1];
        r_zmax  = c_side[B][B];
        r_val   = c_side[B][B-1:0];
        q0 = c_quot[B][0];
        q1 = c_quot[B][1];
        q2 = c_quot[B][2];
        if (r_dir == DIR_FWD) begin
            o0 = r_zspan ? '0 : q0;
            o1 = r_zmax ? '0 : q1;
            o2 = r_val;
        end else begin
            // q0 = p, q1 = q, q2 = t
            case (sect_t'(r_sect))
                SEC_RED:    begin o0 = r_val; o1 = q2;    o2 = q0;    end
                SEC_YELLOW: begin o0 = q1;    o1 = r_val; o2 = q0;    end
                SEC_GREEN:  begin o0 = q0;    o1 = r_val; o2 = q2;    end
                SEC_CYAN:   begin o0 = q0;    o1 = q1;    o2 = r_val; end
                SEC_BLUE:   begin o0 = q2;    o1 = q0;    o2 = r_val; end
                default:    begin o0 = r_val; o1 = q0;    o2 = q1;    end
            endcase
        end
        res = DW_BUS'({o2, o1, o0});
    end

    logic arr;
    assign arr = en && c_valid[B];

    logic              out_v_reg;
    logic [DW_BUS-1:0] out_reg, skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || m_tready) begin
            out_v_reg  <= skid_v_reg || arr;
            skid_v_reg <= 1'b0;
        end else if (arr) begin
            skid_v_reg <= 1'b1;
        end
        if (!out_v_reg || m_tready) begin
            out_reg <= skid_v_reg ? skid_reg : res;
        end else if (arr) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid holds a transaction while output register is empty");

    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && !m_tready && arr) |=> skid_v_reg)
        else $error("arriving transaction lost during output stall");

    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_v_reg && !m_tready) |=> (skid_v_reg && $stable(skid_reg)))
        else $error("skid contents changed while stalled");

endmodule

/* sim/tb.sv */
// Testbench for rgb_hsv_converter_top: directed table plus random pixels in both directions,
// each result checked against an in-bench fixed-point RGB/HSV predictor.
// Depends on rhc_pkg and the converter RTL.
module tb;
    import rhc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 12;
    localparam int DW = ((3*CB+7)/8)*8;
    localparam longint CMAX = (64'd1 << CB) - 1;
    localparam longint HONE = 64'd1 << CB;
    localparam int LATENCY = CB + 4;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CB-1:0] c2;
        logic [CB-1:0] c1;
        logic [CB-1:0] c0;
    } pixel_t;

    typedef struct {
        dir_t   dir;
        pixel_t px;
        bit     known;
        pixel_t res;
    } vec_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wen = 1'b0;
    logic cfg_wdata = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DW-1:0] m_tdata;

    always #5 aclk = ~aclk;

    rgb_hsv_converter_top #(.COMPONENT_BITS(CB)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    dir_t   cur_dir = DIR_FWD;
    pixel_t pending_pixels[$];
    int     errors = 0;
    bit     hold_rx = 1'b0;
    longint cycles = 0;

    function automatic pixel_t predict_fwd(pixel_t p);
        longint r, g, b, hi, lo, span, num;
        pixel_t o;
        r = p.c0; g = p.c1; b = p.c2;
        hi = r; lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        span = hi - lo;
        o = '0;
        if (span != 0) begin
            if (hi == r) num = (g >= b) ? g - b : 6*span - (b - g);
            else if (hi == g) num = 2*span + b - r;
            else num = 4*span + r - g;
            o.c0 = CB'((num * HONE) / (6*span));
        end
        if (hi != 0) o.c1 = CB'((span * CMAX) / hi);
        o.c2 = CB'(hi);
        return o;
    endfunction

    function automatic pixel_t predict_inv(pixel_t p);
        longint h6, f, full, v, s, pv, qv, tv, r, g, b;
        sect_t sec;
        pixel_t o;
        h6 = longint'(p.c0) * 6;
        sec = sect_t'(h6 >> CB);
        f = h6 & CMAX;
        full = CMAX * HONE;
        v = p.c2; s = p.c1;
        pv = (v * (CMAX - s)) / CMAX;
        qv = (v * (full - s*f)) / full;
        tv = (v * (full - s*(HONE - f))) / full;
        case (sec)
            SEC_RED:    begin r = v;  g = tv; b = pv; end
            SEC_YELLOW: begin r = qv; g = v;  b = pv; end
            SEC_GREEN:  begin r = pv; g = v;  b = tv; end
            SEC_CYAN:   begin r = pv; g = qv; b = v;  end
            SEC_BLUE:   begin r = tv; g = pv; b = v;  end
            default:    begin r = v;  g = pv; b = qv; end
        endcase
        o.c0 = CB'(r > CMAX ? CMAX : r);
        o.c1 = CB'(g > CMAX ? CMAX : g);
        o.c2 = CB'(b > CMAX ? CMAX : b);
        return o;
    endfunction

    function automatic pixel_t convert_pixel(dir_t d, pixel_t p);
        return (d == DIR_FWD) ? predict_fwd(p) : predict_inv(p);
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 3) return $urandom_range(10, 40);
        if ($urandom_range(0, 99) < 40) return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_direction(dir_t d);
        wait_drained();
        cfg_wen <= 1'b1;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        cur_dir = d;
    endtask

    // Hands one transaction to the block; expectation queued at acceptance.
    // tvalid stays high afterwards; callers drop it before idling.
    task automatic send_pixel(pixel_t p, bit known, pixel_t res);
        pixel_t e;
        e = convert_pixel(cur_dir, p);
        if (known && e !== res) begin
            $display("%0t: table/predictor mismatch exp %h got %h", $time, res, e);
            errors++;
        end
        s_tvalid <= 1'b1;
        s_tdata <= DW'(p);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_pixels.push_back(e);
    endtask

    function automatic pixel_t rand_pixel(dir_t d);
        pixel_t p;
        int mode;
        p = pixel_t'((3*CB)'({$urandom, $urandom}));
        mode = $urandom_range(0, 9);
        if (mode == 0) p.c1 = p.c0;
        else if (mode == 1) p.c2 = p.c0;
        else if (mode == 2) begin p.c1 = p.c0; p.c2 = p.c0; end
        else if (mode == 3) p.c0 = (mode[0] ? CB'(CMAX) : '0);
        else if (mode == 4 && d == DIR_INV) p.c1 = $urandom_range(0, 1) ? CB'(CMAX) : '0;
        return p;
    endfunction

    // Receiver: random stalls, checks against oldest expectation.
    always @(posedge aclk) begin
        pixel_t got, e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = pixel_t'(m_tdata[3*CB-1:0]);
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    e = pending_pixels.pop_front();
                    if (got.c0 !== e.c0)
                        $display("%0t: chan0 exp %h got %h", $time, e.c0, got.c0);
                    if (got.c1 !== e.c1)
                        $display("%0t: chan1 exp %h got %h", $time, e.c1, got.c1);
                    if (got.c2 !== e.c2)
                        $display("%0t: chan2 exp %h got %h", $time, e.c2, got.c2);
                    if (got !== e) errors++;
                end
            end
            m_tready <= hold_rx ? 1'b0 : ($urandom_range(0, 99) < 70);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    vec_t table_rows[$];

    task automatic add_row(dir_t d, int a, int b, int c, bit k, int ra, int rb, int rc);
        vec_t v;
        v.dir = d;
        v.px = '{c2: CB'(c), c1: CB'(b), c0: CB'(a)};
        v.known = k;
        v.res = '{c2: CB'(rc), c1: CB'(rb), c0: CB'(ra)};
        table_rows.push_back(v);
    endtask

    initial begin
        int m;
        int gap;
        pixel_t z;
        m = int'(CMAX);
        z = '0;
        // forward: black, white, gray, primaries, ties, red wrap
        add_row(DIR_FWD, 0, 0, 0, 1, 0, 0, 0);
        add_row(DIR_FWD, m, m, m, 1, 0, 0, m);
        add_row(DIR_FWD, 1000, 1000, 1000, 1, 0, 0, 1000);
        add_row(DIR_FWD, m, 0, 0, 1, 0, m, m);
        add_row(DIR_FWD, 0, m, 0, 1, 1365, m, m);
        add_row(DIR_FWD, 0, 0, m, 1, 2730, m, m);
        add_row(DIR_FWD, m, m, 0, 0, 0, 0, 0);
        add_row(DIR_FWD, 0, m, m, 0, 0, 0, 0);
        add_row(DIR_FWD, m, 0, m, 0, 0, 0, 0);
        add_row(DIR_FWD, m, 0, 1, 0, 0, 0, 0);
        add_row(DIR_FWD, 1, 0, 0, 1, 0, m, 1);
        add_row(DIR_FWD, 2048, 1024, 3000, 0, 0, 0, 0);
        // inverse: zero sat/value, each sector, top hue
        add_row(DIR_INV, 0, 0, m, 1, m, m, m);
        add_row(DIR_INV, 0, m, 0, 1, 0, 0, 0);
        add_row(DIR_INV, 0, m, m, 1, m, 0, 0);
        add_row(DIR_INV, 700, m, m, 0, 0, 0, 0);
        add_row(DIR_INV, 1400, m, m, 0, 0, 0, 0);
        add_row(DIR_INV, 2100, m, m, 0, 0, 0, 0);
        add_row(DIR_INV, 2800, m, m, 0, 0, 0, 0);
        add_row(DIR_INV, 3500, m, m, 0, 0, 0, 0);
        add_row(DIR_INV, m, m, m, 0, 0, 0, 0);
        add_row(DIR_INV, m, 2000, 3000, 0, 0, 0, 0);
        add_row(DIR_INV, 1234, 0, 2222, 1, 2222, 2222, 2222);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (table_rows[i]) begin
            if (table_rows[i].dir != cur_dir) set_direction(table_rows[i].dir);
            send_pixel(table_rows[i].px, table_rows[i].known, table_rows[i].res);
        end

        set_direction(DIR_FWD);
        for (int n = 0; n < 1200; n++) begin
            if (n % 300 == 0 && n != 0)
                set_direction(cur_dir == DIR_FWD ? DIR_INV : DIR_FWD);
            if (n == 150) begin
                // long receiver hold-off: block fills and stalls its input
                fork
                    begin
                        hold_rx = 1'b1;
                        repeat (200) @(posedge aclk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            if (n == 450) wait_drained();
            gap = gap_len();
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            send_pixel(rand_pixel(cur_dir), 1'b0, z);
        end

        wait_drained();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

/* filelist.f */
src/rhc_pkg.sv
src/rhc_prep.sv
src/rhc_div_cell.sv
src/rgb_hsv_converter_top.sv
sim/tb.sv
